### rtl/serfrx_pkg.sv
// shared types and constants for the serial frame receiver
`default_nettype none
package serfrx_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// parser phases
	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_RECEIVER = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LENGTH   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_COMMAND  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CHECK    = 3'd5;
	localparam logic [PHASE_W-1:0] PH_READY    = 3'd6;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_SENDER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECEIVER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND  = 2'd2;

	// request opcodes
	localparam logic OP_LINE_BYTE = 1'b0;
	localparam logic OP_RELEASE   = 1'b1;

	// shortest legal frame: sender, receiver, length, command, checksum
	localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd5;

	typedef struct packed {
		logic              byte_kept;
		logic [BYTE_W-1:0] kept_value;
		logic [BYTE_W-1:0] byte_position;
		logic              frame_ready;
		logic              frame_error;
		logic [BYTE_W-1:0] frame_byte_count;
	} result_t;

endpackage
`default_nettype wire

### rtl/serial_frame_receiver_xor.sv
// top level of the length-prefixed frame parser with xor checksum
`default_nettype none
//
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// input     | in_valid / in_ready    | op, data_byte
// output    | out_valid / out_ready  | byte_kept, kept_value, byte_position,
//           |                        | frame_ready, frame_error, frame_byte_count
// config    | cfg_we                 | cfg_index, cfg_data
//
// each request is parsed in the cycle it is accepted and its result is registered;
// a new request may be taken every cycle while in_ready is high
// a result register plus one skid entry decouple the sides: in_ready drops
// only while the skid entry holds a stalled result
// arst_n clears the parser phase, counters, checksum and config registers
//
module serial_frame_receiver_xor (
	input  wire                                clk,
	input  wire                                arst_n,
	// config write port
	input  wire                                cfg_we,
	input  wire [serfrx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [serfrx_pkg::BYTE_W-1:0]       cfg_data,
	// request channel
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                op,
	input  wire [serfrx_pkg::BYTE_W-1:0]       data_byte,
	// result channel
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               byte_kept,
	output logic [serfrx_pkg::BYTE_W-1:0]      kept_value,
	output logic [serfrx_pkg::BYTE_W-1:0]      byte_position,
	output logic                               frame_ready,
	output logic                               frame_error,
	output logic [serfrx_pkg::BYTE_W-1:0]      frame_byte_count
);

	// config registers
	logic [serfrx_pkg::BYTE_W-1:0] sender_code_q;
	logic [serfrx_pkg::BYTE_W-1:0] receiver_code_q;
	logic [serfrx_pkg::BYTE_W-1:0] command_code_q;

	// parser state
	logic [serfrx_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [serfrx_pkg::BYTE_W-1:0]  xor_q, xor_d;
	logic [serfrx_pkg::BYTE_W-1:0]  remain_q, remain_d;
	logic [serfrx_pkg::BYTE_W-1:0]  count_q, count_d;

	// result path
	serfrx_pkg::result_t res;
	serfrx_pkg::result_t out_q;
	serfrx_pkg::result_t skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;

	logic                          push;
	logic                          kept;
	logic                          err;
	logic                          go_idle;
	logic [serfrx_pkg::BYTE_W-1:0] xor_base;
	logic [serfrx_pkg::BYTE_W-1:0] count_base;
	logic [serfrx_pkg::BYTE_W-1:0] remain_dec;

	assign in_ready = !skid_valid_q;
	assign push     = in_valid && in_ready;

	// config writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_code_q   <= '0;
			receiver_code_q <= '0;
			command_code_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				serfrx_pkg::REG_SENDER:   sender_code_q   <= cfg_data;
				serfrx_pkg::REG_RECEIVER: receiver_code_q <= cfg_data;
				serfrx_pkg::REG_COMMAND:  command_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign remain_dec = (remain_q != '0) ? remain_q - 8'd1 : remain_q;

	// one parser step per request
	always_comb begin
		phase_d    = phase_q;
		remain_d   = remain_q;
		xor_base   = xor_q;
		count_base = count_q;
		kept       = 1'b0;
		err        = 1'b0;
		go_idle    = 1'b0;

		if (op == serfrx_pkg::OP_RELEASE) begin
			if (phase_q == serfrx_pkg::PH_READY) begin
				go_idle = 1'b1;
			end
		end else begin
			case (phase_q)
				serfrx_pkg::PH_IDLE: begin
					// a sender byte opens a fresh frame
					if (data_byte == sender_code_q) begin
						count_base = '0;
						xor_base   = '0;
						remain_d   = '0;
						kept       = 1'b1;
						phase_d    = serfrx_pkg::PH_RECEIVER;
					end
				end
				serfrx_pkg::PH_RECEIVER: begin
					if (data_byte == receiver_code_q) begin
						kept    = 1'b1;
						phase_d = serfrx_pkg::PH_LENGTH;
					end else begin
						go_idle = 1'b1;
					end
				end
				serfrx_pkg::PH_LENGTH: begin
					// too short to hold even the header and checksum
					if (data_byte < serfrx_pkg::MIN_FRAME_LEN) begin
						err     = 1'b1;
						go_idle = 1'b1;
					end else begin
						kept     = 1'b1;
						remain_d = data_byte - serfrx_pkg::MIN_FRAME_LEN;
						phase_d  = serfrx_pkg::PH_COMMAND;
					end
				end
				serfrx_pkg::PH_COMMAND: begin
					if (data_byte == command_code_q) begin
						kept    = 1'b1;
						// no payload: checksum comes next
						phase_d = (remain_q == '0) ? serfrx_pkg::PH_CHECK
						                           : serfrx_pkg::PH_PAYLOAD;
					end else begin
						go_idle = 1'b1;
					end
				end
				serfrx_pkg::PH_PAYLOAD: begin
					kept     = 1'b1;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						phase_d = serfrx_pkg::PH_CHECK;
					end
				end
				serfrx_pkg::PH_CHECK: begin
					if (data_byte == xor_q) begin
						phase_d = serfrx_pkg::PH_READY;
					end else begin
						err     = 1'b1;
						go_idle = 1'b1;
					end
				end
				serfrx_pkg::PH_READY: begin
					// line bytes are ignored while a frame is held
				end
				default: begin
					go_idle = 1'b1;
				end
			endcase
		end

		if (go_idle) begin
			phase_d    = serfrx_pkg::PH_IDLE;
			count_base = '0;
		end

		xor_d   = kept ? (xor_base ^ data_byte) : xor_base;
		count_d = kept ? (count_base + 8'd1) : count_base;

		res.byte_kept        = kept;
		res.kept_value       = kept ? data_byte : '0;
		res.byte_position    = kept ? count_base : '0;
		res.frame_ready      = (phase_d == serfrx_pkg::PH_READY);
		res.frame_error      = err;
		res.frame_byte_count = count_d;
	end

	// parser state advances once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= serfrx_pkg::PH_IDLE;
			xor_q    <= '0;
			remain_q <= '0;
			count_q  <= '0;
		end else if (push) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			remain_q <= remain_d;
			count_q  <= count_d;
		end
	end

	// result register and skid entry: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			// result slot free or draining: refill from skid first
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// result register and skid entry: payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign byte_kept        = out_q.byte_kept;
	assign kept_value       = out_q.kept_value;
	assign byte_position    = out_q.byte_position;
	assign frame_ready      = out_q.frame_ready;
	assign frame_error      = out_q.frame_error;
	assign frame_byte_count = out_q.frame_byte_count;

endmodule
`default_nettype wire
